@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ src/mmwg_pkg.sv @@
// Types, codes and sine table function of the waveform generator.
package mmwg_pkg;

  localparam int DEFAULT_CYCLE_LENGTH = 64;
  localparam int SAMPLE_W = 16;
  localparam int MODE_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int FRAC_BITS = 30;

  localparam logic [MODE_W-1:0] MODE_SILENCE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SINE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COSINE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RAMP     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DC_OFFSET = 2'd2;

  // Smallest fraction that marks a nonzero remainder of the scaled slope.
  localparam logic [FRAC_BITS-1:0] NZ_MIN = 30'h0002_0000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] HALF_PI = (64'd314159 << 30) / 64'd200000;

  typedef struct packed {
    logic [MODE_W-1:0]          wave_mode;
    logic signed [SAMPLE_W-1:0] amplitude;
    logic signed [SAMPLE_W-1:0] dc_offset;
  } cfg_t;

  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // Q1.15 sine of a turn fraction t / 2^32.
  function automatic logic signed [15:0] sine_q15(input logic [31:0] t);
    logic [1:0]  quad;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] k;
    logic [63:0] s;
    logic [63:0] r;
    logic [15:0] r16;
    quad = t[31:30];
    f = {34'd0, t[29:0]};
    if (quad[0]) begin
      f = Q30_ONE - f;
    end
    x  = mulq30(f, HALF_PI);
    x2 = mulq30(x, x);
    k  = Q30_ONE - x2 / 64'd110;
    k  = Q30_ONE - mulq30(x2 / 64'd72, k);
    k  = Q30_ONE - mulq30(x2 / 64'd42, k);
    k  = Q30_ONE - mulq30(x2 / 64'd20, k);
    k  = Q30_ONE - mulq30(x2 / 64'd6, k);
    s  = mulq30(x, k);
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    r16 = r[15:0];
    return quad[1] ? -$signed(r16) : $signed(r16);
  endfunction

endpackage

@@ src/mmwg_core.sv @@
// Sample datapath: wave tables, scaling, offset and saturation.
module mmwg_core #(
  parameter int CYCLE_LENGTH = mmwg_pkg::DEFAULT_CYCLE_LENGTH,
  parameter int PW = $clog2(CYCLE_LENGTH)
) (
  input  logic [PW-1:0]                       phase,
  input  mmwg_pkg::cfg_t                      cfg,
  output logic signed [mmwg_pkg::SAMPLE_W-1:0] sample
);
  import mmwg_pkg::*;

  localparam int HALF = CYCLE_LENGTH / 2;

  logic signed [15:0] sin_rom [CYCLE_LENGTH];
  logic signed [15:0] cos_rom [CYCLE_LENGTH];
  logic [30:0]        ramp_rom [CYCLE_LENGTH];
  logic [30:0]        tri_rom [CYCLE_LENGTH];

  for (genvar g = 0; g < CYCLE_LENGTH; g++) begin : g_rom
    localparam logic [63:0] TS = (64'(g) << 32) / 64'(CYCLE_LENGTH);
    localparam logic [31:0] TS32 = TS[31:0];
    localparam logic [31:0] TC32 = TS32 + 32'h4000_0000;
    localparam logic [63:0] RF =
      ((64'(g) << FRAC_BITS) + 64'(CYCLE_LENGTH - 1)) / 64'(CYCLE_LENGTH);
    localparam int J = (g <= HALF) ? g : g - HALF;
    localparam logic [63:0] TF = ((64'(J) << FRAC_BITS) + 64'(HALF - 1)) / 64'(HALF);
    assign sin_rom[g]  = sine_q15(TS32);
    assign cos_rom[g]  = sine_q15(TC32);
    assign ramp_rom[g] = RF[30:0];
    assign tri_rom[g]  = TF[30:0];
  end

  logic signed [15:0] a;
  logic signed [15:0] o;
  logic               p_le_half;
  logic signed [16:0] lo;
  logic signed [16:0] hi;
  logic [15:0]        a_mag;
  logic [16:0]        u;
  logic               m_neg;
  logic signed [16:0] base;
  logic [30:0]        frac;
  logic [47:0]        prod;
  logic [16:0]        qa;
  logic               nz;
  logic signed [17:0] qa_s;
  logic signed [17:0] qy;
  logic signed [18:0] lin_sum;
  logic signed [18:0] lin_v;
  logic signed [15:0] s;
  logic signed [31:0] prod_s;
  logic signed [31:0] adj;
  logic signed [16:0] q_s;
  logic signed [18:0] sine_v;
  logic signed [18:0] square_v;
  logic signed [18:0] v;

  assign a = cfg.amplitude;
  assign o = cfg.dc_offset;
  assign p_le_half = (phase <= PW'(HALF));
  assign lo = 17'(o) - 17'(a);
  assign hi = 17'(o) + 17'(a);
  assign a_mag = a[15] ? (~$unsigned(a) + 16'd1) : $unsigned(a);
  assign u = {a_mag, 1'b0};

  always_comb begin
    if (cfg.wave_mode == MODE_RAMP) begin
      frac  = ramp_rom[phase];
      base  = lo;
      m_neg = a[15];
    end else if (p_le_half) begin
      frac  = tri_rom[phase];
      base  = lo;
      m_neg = a[15];
    end else begin
      frac  = tri_rom[phase];
      base  = hi;
      m_neg = !a[15];
    end
  end

  assign prod = 48'(u) * 48'(frac);
  assign qa = prod[46:30];
  assign nz = (prod[29:0] >= NZ_MIN);
  assign qa_s = $signed({1'b0, qa});
  assign qy = m_neg ? (-qa_s - $signed({17'd0, nz})) : qa_s;
  assign lin_sum = 19'(base) + 19'(qy);
  assign lin_v = lin_sum + ((lin_sum[18] && nz) ? 19'sd1 : 19'sd0);

  assign s = (cfg.wave_mode == MODE_COSINE) ? cos_rom[phase] : sin_rom[phase];
  assign prod_s = 32'(a) * 32'(s);
  assign adj = prod_s + (prod_s[31] ? 32'sd32767 : 32'sd0);
  assign q_s = $signed(adj[31:15]);
  assign sine_v = 19'(o) + 19'(q_s);

  assign square_v = p_le_half ? (19'(o) + 19'(a)) : (19'(o) - 19'(a));

  always_comb begin
    unique case (cfg.wave_mode) inside
      MODE_SINE, MODE_COSINE: v = sine_v;
      MODE_SQUARE:            v = square_v;
      MODE_RAMP, MODE_TRIANGLE: v = lin_v;
      default:                v = 19'sd0;
    endcase
  end

  always_comb begin
    if (v > 19'sd32767) begin
      sample = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      sample = 16'sh8000;
    end else begin
      sample = v[15:0];
    end
  end

endmodule

@@ src/multi_mode_waveform_generator.sv @@
// Top level of the multi-mode waveform generator.
// Each accepted input transaction yields one signed 16-bit sample in the result register; a new
// transaction is taken every cycle while the result register is free or being drained, so
// the sustained rate is one sample per cycle. The phase counter, the constant wave tables
// of CYCLE_LENGTH entries and two multipliers (sine/cosine, ramp/triangle) sit in a single
// pass between the phase register and the result register.
module multi_mode_waveform_generator #(
  parameter int CYCLE_LENGTH = mmwg_pkg::DEFAULT_CYCLE_LENGTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mmwg_pkg::SAMPLE_W-1:0]  sample_value,
  output logic                                  cycle_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmwg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mmwg_pkg::SAMPLE_W-1:0]         cfg_data
);
  import mmwg_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = $clog2(CYCLE_LENGTH);
  localparam logic [PW-1:0] LAST = PW'(CYCLE_LENGTH - 1);

  cfg_t               cfg;
  logic [PW-1:0]      phase;
  logic [PW-1:0]      p_eff;
  logic               last;
  logic               advance;
  logic signed [15:0] sample_next;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid && out_stall;
  assign advance = in_valid && !in_stall;
  assign p_eff = restart ? '0 : phase;
  assign last = (p_eff == LAST);

  mmwg_core #(
    .CYCLE_LENGTH(CYCLE_LENGTH),
    .PW(PW)
  ) u_core (
    .phase(p_eff),
    .cfg(cfg),
    .sample(sample_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_mode <= MODE_SILENCE;
      cfg.amplitude <= '0;
      cfg.dc_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVE_MODE: cfg.wave_mode <= cfg_data[MODE_W-1:0];
        CFG_AMPLITUDE: cfg.amplitude <= $signed(cfg_data);
        CFG_DC_OFFSET: cfg.dc_offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase <= last ? '0 : p_eff + 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_value <= sample_next;
      cycle_end <= last;
    end
  end

  `ASSERT_CLK(a_phase_range, clk, rst, phase <= LAST)
  `ASSERT_CLK(a_cycle_end, clk, rst, advance |=> (cycle_end == $past(p_eff == LAST)))
  `ASSERT_CLK(a_wrap, clk, rst, (advance && last) |=> (phase == '0))
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

endmodule
